// ===== design/bmh_pkg.sv =====
// Shared types and codes for the binary min-heap priority queue.
// No dependencies.
package bmh_pkg;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_EXTRACT  = 2'd1,
        OP_FIND     = 2'd2,
        OP_DECREASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADPOS   = 3'd4,
        ST_NOTDEC   = 3'd5
    } status_t;

    // One accepted item as carried from front to back.
    typedef struct packed {
        op_t         op;
        logic [15:0] node;
        logic [15:0] from;
        logic [15:0] to;
        logic [31:0] cost;
        logic [7:0]  pos;
    } cmd_t;

    // One result item.
    typedef struct packed {
        status_t     status;
        logic [15:0] node;
        logic [15:0] from;
        logic [15:0] to;
        logic [31:0] cost;
        logic [7:0]  fpos;
    } rsp_t;

    // Heap entry as stored in memory.
    typedef struct packed {
        logic [31:0] cost;
        logic [15:0] node;
        logic [31:0] edge_pair;
    } entry_t;

endpackage

// ===== design/bmh_cmd_fifo.sv =====
// Two-entry command queue between the input side and the heap engine.
// Depends on bmh_pkg.
module bmh_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  bmh_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output bmh_pkg::cmd_t rd_data,
    output logic          empty
);
    import bmh_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_en && !full} - {1'b0, rd_en && !empty};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("command queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !full && !(rd_en && !empty)) |=> !empty)
        else $error("write lost in command queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(full && empty))
        else $error("queue both full and empty");
endmodule

// ===== design/bmh_engine.sv =====
// Heap engine: executes one command at a time on the entry memory.
// Depends on bmh_pkg.
module bmh_engine
#(
    parameter int CAPACITY = 256,
    parameter int AW       = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  bmh_pkg::cmd_t cmd,
    output logic          cmd_take,
    output logic          rsp_valid,
    output bmh_pkg::rsp_t rsp,
    input  logic          rsp_take
);
    import bmh_pkg::*;

    localparam logic [AW:0] CAP = AW'(0) + (AW+1)'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_RD_A, S_WAIT_A, S_RD_B, S_WAIT_B,
        S_RD_C, S_WAIT_C, S_DECIDE, S_WR, S_SCAN, S_SCAN_CHK, S_RESP
    } state_t;

    // Memory with registered read
    entry_t      ram [CAPACITY];
    logic        we;
    logic [AW-1:0] waddr, raddr;
    entry_t      wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
        rdata_reg <= ram[raddr];
    end

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic [AW:0] count_reg;
    logic [AW:0] pos_reg;     // current sift position
    logic [AW:0] oth_reg;     // parent or chosen child
    logic        down_reg;
    entry_t      cur_reg, a_reg, b_reg;
    logic        bval_reg;
    logic [AW:0] rchild_reg;
    logic [1:0]  wr_step_reg;
    rsp_t        rsp_reg;
    logic        rv_reg;

    logic [AW:0] lchild;
    assign lchild = {pos_reg[AW-1:0], 1'b1};

    assign rsp_valid = rv_reg;
    assign rsp       = rsp_reg;
    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid && !rv_reg;

    // Memory port control
    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg[AW-1:0];
        wdata = cur_reg;
        raddr = pos_reg[AW-1:0];
        case (state_reg)
            S_RD_A:  raddr = pos_reg[AW-1:0];
            S_RD_B:  raddr = oth_reg[AW-1:0];
            S_RD_C:  raddr = rchild_reg[AW-1:0];
            S_SCAN:  raddr = pos_reg[AW-1:0];
            S_WR:
            begin
                we = 1'b1;
                if (wr_step_reg == 2'd0)
                begin
                    waddr = pos_reg[AW-1:0];
                    wdata = a_reg;
                end
                else
                begin
                    waddr = oth_reg[AW-1:0];
                    wdata = cur_reg;
                end
            end
            S_DISPATCH:
            begin
                raddr = '0;
                if (cmd_reg.op == OP_INSERT && count_reg != CAP)
                begin
                    we    = 1'b1;
                    waddr = count_reg[AW-1:0];
                    wdata = '{cost: cmd_reg.cost, node: cmd_reg.node,
                              edge_pair: {cmd_reg.from, cmd_reg.to}};
                end
            end
            default: ;
        endcase
    end

    // Main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rv_reg      <= 1'b0;
            pos_reg     <= '0;
            oth_reg     <= '0;
            down_reg    <= 1'b0;
            bval_reg    <= 1'b0;
            rchild_reg  <= '0;
            wr_step_reg <= '0;
        end
        else
        begin
            if (rv_reg && rsp_take)
            begin
                rv_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        cmd_reg   <= cmd;
                        rsp_reg   <= '{status: ST_OK, default: '0};
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    down_reg    <= 1'b0;
                    wr_step_reg <= 2'd0;
                    case (cmd_reg.op)
                        OP_INSERT:
                        begin
                            if (count_reg == CAP)
                            begin
                                rsp_reg.status <= ST_FULL;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                pos_reg   <= count_reg;
                                count_reg <= count_reg + 1'b1;
                                state_reg <= S_RD_A;
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_reg.status <= ST_EMPTY;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                // root read issued this cycle
                                count_reg <= count_reg - 1'b1;
                                oth_reg   <= count_reg - 1'b1;
                                state_reg <= S_WAIT_A;
                            end
                        end
                        OP_FIND:
                        begin
                            pos_reg        <= '0;
                            rsp_reg.status <= ST_NOTFOUND;
                            state_reg      <= S_SCAN;
                        end
                        default:
                        begin
                            if ({1'b0, cmd_reg.pos} >= count_reg)
                            begin
                                rsp_reg.status <= ST_BADPOS;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                pos_reg   <= (AW+1)'(cmd_reg.pos);
                                state_reg <= S_RD_A;
                            end
                        end
                    endcase
                end
                // Read current entry at pos
                S_RD_A:
                begin
                    oth_reg   <= pos_reg;
                    state_reg <= S_WAIT_A;
                end
                S_WAIT_A:
                begin
                    if (cmd_reg.op == OP_EXTRACT && !down_reg)
                    begin
                        // rdata is root: report it, then fetch last entry
                        rsp_reg.node <= rdata_reg.node;
                        rsp_reg.from <= rdata_reg.edge_pair[31:16];
                        rsp_reg.to   <= rdata_reg.edge_pair[15:0];
                        rsp_reg.cost <= rdata_reg.cost;
                        if (count_reg == '0)
                        begin
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            down_reg  <= 1'b1;
                            pos_reg   <= '0;
                            state_reg <= S_RD_B;
                        end
                    end
                    else if (cmd_reg.op == OP_DECREASE && !down_reg)
                    begin
                        if ($signed(cmd_reg.cost) > $signed(rdata_reg.cost))
                        begin
                            rsp_reg.status <= ST_NOTDEC;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            cur_reg      <= '{cost: cmd_reg.cost, node: rdata_reg.node,
                                              edge_pair: rdata_reg.edge_pair};
                            down_reg     <= 1'b1;
                            wr_step_reg  <= 2'd1;
                            oth_reg      <= pos_reg;
                            state_reg    <= S_WR;
                        end
                    end
                    else
                    begin
                        cur_reg <= rdata_reg;
                        if (pos_reg == '0)
                        begin
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            oth_reg   <= (pos_reg - 1'b1) >> 1;
                            state_reg <= S_RD_C;
                            rchild_reg <= (pos_reg - 1'b1) >> 1;
                        end
                    end
                end
                // Sift-down: fetched moved entry, write root, then children
                S_RD_B:
                begin
                    state_reg <= S_WAIT_B;
                end
                S_WAIT_B:
                begin
                    if (cmd_reg.op == OP_EXTRACT && wr_step_reg == 2'd0 &&
                        pos_reg == '0 && oth_reg == count_reg)
                    begin
                        cur_reg     <= rdata_reg;
                        oth_reg     <= '0;
                        wr_step_reg <= 2'd1;
                        state_reg   <= S_WR;
                    end
                    else
                    begin
                        a_reg <= rdata_reg;
                        if (rchild_reg < count_reg)
                        begin
                            state_reg <= S_RD_C;
                        end
                        else
                        begin
                            bval_reg  <= 1'b0;
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_RD_C:
                begin
                    state_reg <= S_WAIT_C;
                end
                S_WAIT_C:
                begin
                    if (cmd_reg.op == OP_EXTRACT)
                    begin
                        b_reg     <= rdata_reg;
                        bval_reg  <= 1'b1;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        // sift-up compare with parent
                        if ($signed(rdata_reg.cost) > $signed(cur_reg.cost))
                        begin
                            a_reg       <= rdata_reg;
                            wr_step_reg <= 2'd0;
                            state_reg   <= S_WR;
                        end
                        else
                        begin
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_DECIDE:
                begin
                    // a = left child, b = right child (if valid)
                    if (bval_reg && $signed(b_reg.cost) < $signed(a_reg.cost) &&
                        $signed(b_reg.cost) < $signed(cur_reg.cost))
                    begin
                        a_reg       <= b_reg;
                        oth_reg     <= rchild_reg;
                        wr_step_reg <= 2'd0;
                        state_reg   <= S_WR;
                    end
                    else if ($signed(a_reg.cost) < $signed(cur_reg.cost))
                    begin
                        oth_reg     <= lchild;
                        wr_step_reg <= 2'd0;
                        state_reg   <= S_WR;
                    end
                    else
                    begin
                        state_reg <= S_RESP;
                    end
                end
                // Swap: write other entry at pos, then cur at oth
                S_WR:
                begin
                    if (wr_step_reg == 2'd0)
                    begin
                        wr_step_reg <= 2'd1;
                    end
                    else
                    begin
                        wr_step_reg <= 2'd2;
                        pos_reg     <= oth_reg;
                        if (cmd_reg.op == OP_EXTRACT)
                        begin
                            if ({oth_reg[AW-1:0], 1'b1} < count_reg && oth_reg[AW] == 1'b0)
                            begin
                                oth_reg    <= {oth_reg[AW-1:0], 1'b1};
                                rchild_reg <= {oth_reg[AW-1:0], 1'b1} + 1'b1;
                                state_reg  <= S_RD_B;
                            end
                            else
                            begin
                                state_reg <= S_RESP;
                            end
                        end
                        else if (oth_reg == '0)
                        begin
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            // next parent address goes out on the read port
                            oth_reg    <= (oth_reg - 1'b1) >> 1;
                            rchild_reg <= (oth_reg - 1'b1) >> 1;
                            state_reg  <= S_RD_C;
                        end
                    end
                end
                // Linear scan for node id
                S_SCAN:
                begin
                    if (pos_reg >= count_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (rdata_reg.node == cmd_reg.node)
                    begin
                        rsp_reg.status <= ST_OK;
                        rsp_reg.fpos   <= 8'(pos_reg);
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_RESP:
                begin
                    if (!rv_reg)
                    begin
                        rv_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP)
        else $error("entry count above capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !we)
        else $error("memory write while idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> (state_reg == S_DISPATCH))
        else $error("accepted command not dispatched");
endmodule

// ===== design/binary_min_heap_priority_queue.sv =====
// Binary min-heap priority queue: command queue in front of a heap engine.
// Depends on bmh_pkg, bmh_cmd_fifo, bmh_engine.
// One item at a time in the engine over one entry memory with a registered
// read port and a separate write port: insert and decrease sift up, extract
// sifts down, find is a linear scan. Reset empties the heap; memory is not cleared.
module binary_min_heap_priority_queue
#(
    parameter int CAPACITY = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [15:0] node_id,
    input  logic [15:0] edge_from,
    input  logic [15:0] edge_to,
    input  logic [31:0] key_cost,
    input  logic [7:0]  heap_position,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [15:0] out_node,
    output logic [15:0] out_from,
    output logic [15:0] out_to,
    output logic [31:0] out_cost,
    output logic [7:0]  found_position
);
    import bmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    cmd_t in_cmd, q_cmd;
    logic q_empty, take;
    logic rv;
    rsp_t r;

    assign in_cmd = '{op: op_t'(operation), node: node_id, from: edge_from,
                      to: edge_to, cost: key_cost, pos: heap_position};

    bmh_cmd_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_en(push), .wr_data(in_cmd), .full(full),
        .rd_en(take), .rd_data(q_cmd), .empty(q_empty)
    );

    bmh_engine #(.CAPACITY(CAPACITY), .AW(AW)) u_engine (
        .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_cmd),
        .cmd_take(take), .rsp_valid(rv), .rsp(r), .rsp_take(pop)
    );

    // Result ports
    assign empty          = !rv;
    assign status         = r.status;
    assign out_node       = r.node;
    assign out_from       = r.from;
    assign out_to         = r.to;
    assign out_cost       = r.cost;
    assign found_position = r.fpos;
endmodule
